// File: hdl/ultrasonic_level_valve_controller_assert.svh
// Assertion macros for the checker file.
`ifndef ULTRASONIC_LEVEL_VALVE_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_LEVEL_VALVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ULVC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, disabled during reset.
`define ULVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// File: hdl/ulvc_pkg.sv
package ulvc_pkg;

  typedef enum logic [4:0] {
    PH_SETTLE  = 5'b00001,
    PH_TRIG    = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_MEASURE = 5'b01000,
    PH_PAUSE   = 5'b10000
  } phase_t;

  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_RED   = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_BLUE  = 2'd3;

  localparam logic [2:0] REG_THRESHOLD_DIST = 3'd0;
  localparam logic [2:0] REG_TRIGGER_TICKS  = 3'd1;
  localparam logic [2:0] REG_START_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_END_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_PAUSE_TICKS    = 3'd4;

  localparam logic [19:0] SETTLE_TICKS = 20'd2;
  localparam logic [16:0] CNT17_MAX    = 17'h1FFFF;
  localparam logic [12:0] DIST_MUL     = 13'd7025;
  localparam int unsigned DIST_SHIFT   = 12;

  localparam logic [17:0] RST_THRESHOLD_DIST = 18'd150;
  localparam logic [7:0]  RST_TRIGGER_TICKS  = 8'd10;
  localparam logic [16:0] RST_START_TIMEOUT  = 17'd50000;
  localparam logic [16:0] RST_END_TIMEOUT    = 17'd100000;
  localparam logic [19:0] RST_PAUSE_TICKS    = 20'd1000000;

endpackage

// File: hdl/ultrasonic_level_valve_controller.sv
// A result is written to the output register at the edge that accepts its tick.
// Throughput: one tick per cycle while in_stall is low; the sequencer, counters
// and 17x13 distance multiply all settle between state and output registers.
// Reset (rst, synchronous): phase returns to trigger-low settle, counters and
// status clear, configuration returns to its default values, no result is pending.
module ultrasonic_level_valve_controller
  import ulvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        echo_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        trigger_level,
  output logic        valve_open,
  output logic [1:0]  led_color,
  output logic [17:0] distance_out,
  output logic        result_strobe,
  output logic        sensor_error,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [17:0] threshold_dist;
  logic [7:0]  trigger_ticks;
  logic [16:0] start_timeout;
  logic [16:0] end_timeout;
  logic [19:0] pause_ticks;

  phase_t      phase, phase_next;
  logic [19:0] phase_ticks, phase_ticks_next;
  logic [16:0] since_trigger, since_trigger_next;
  logic [16:0] echo_width, echo_width_next;
  logic        valve_reg, valve_reg_next;
  logic [1:0]  led_reg, led_reg_next;
  logic [17:0] distance_reg, distance_reg_next;
  logic        error_reg, error_reg_next;

  logic        trig;
  logic        strobe;
  logic        done;
  logic        failed;
  logic        in_accept;
  logic [19:0] ticks_inc;
  logic [19:0] trig_len;
  logic [17:0] elapsed;
  logic [16:0] since_sat;
  logic [29:0] dist_prod;
  logic [17:0] dist_calc;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign ticks_inc = phase_ticks + 20'd1;
  assign trig_len  = (trigger_ticks == 8'd0) ? 20'd1 : {12'd0, trigger_ticks};
  assign elapsed   = {1'b0, since_trigger} + 18'd1;
  assign since_sat = elapsed[17] ? CNT17_MAX : elapsed[16:0];
  assign dist_prod = 30'(echo_width) * 30'(DIST_MUL);
  assign dist_calc = dist_prod[DIST_SHIFT +: 18];

  always_comb begin
    phase_next         = phase;
    phase_ticks_next   = phase_ticks;
    since_trigger_next = since_trigger;
    echo_width_next    = echo_width;
    valve_reg_next     = valve_reg;
    led_reg_next       = led_reg;
    distance_reg_next  = distance_reg;
    error_reg_next     = error_reg;
    trig   = 1'b0;
    done   = 1'b0;
    failed = 1'b0;
    case (phase)
      PH_SETTLE: begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= SETTLE_TICKS) begin
          phase_next       = PH_TRIG;
          phase_ticks_next = '0;
        end
      end
      PH_TRIG: begin
        trig             = 1'b1;
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= trig_len) begin
          phase_next         = PH_WAIT;
          phase_ticks_next   = '0;
          since_trigger_next = '0;
          echo_width_next    = '0;
        end
      end
      PH_WAIT: begin
        since_trigger_next = since_sat;
        if (echo_level) begin
          echo_width_next = 17'd1;
          phase_next      = PH_MEASURE;
        end else if (elapsed > {1'b0, start_timeout}) begin
          done   = 1'b1;
          failed = 1'b1;
        end
      end
      PH_MEASURE: begin
        since_trigger_next = since_sat;
        if (!echo_level) begin
          done = 1'b1;
        end else begin
          if (echo_width != CNT17_MAX) begin
            echo_width_next = echo_width + 17'd1;
          end
          if (elapsed > {1'b0, end_timeout}) begin
            done   = 1'b1;
            failed = 1'b1;
          end
        end
      end
      PH_PAUSE: begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= pause_ticks) begin
          phase_next       = PH_SETTLE;
          phase_ticks_next = '0;
        end
      end
      default: begin
        phase_next       = PH_SETTLE;
        phase_ticks_next = 20'd1;
      end
    endcase

    if (done) begin
      if (failed) begin
        error_reg_next = 1'b1;
        valve_reg_next = 1'b0;
        led_reg_next   = LED_RED;
      end else begin
        distance_reg_next = dist_calc;
        error_reg_next    = 1'b0;
        if (dist_calc <= threshold_dist) begin
          valve_reg_next = 1'b1;
          led_reg_next   = LED_GREEN;
        end else begin
          valve_reg_next = 1'b0;
          led_reg_next   = LED_BLUE;
        end
      end
      phase_ticks_next = '0;
      phase_next       = (pause_ticks == 20'd0) ? PH_SETTLE : PH_PAUSE;
    end
    strobe = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_dist <= RST_THRESHOLD_DIST;
      trigger_ticks  <= RST_TRIGGER_TICKS;
      start_timeout  <= RST_START_TIMEOUT;
      end_timeout    <= RST_END_TIMEOUT;
      pause_ticks    <= RST_PAUSE_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD_DIST: threshold_dist <= cfg_data[17:0];
        REG_TRIGGER_TICKS:  trigger_ticks  <= cfg_data[7:0];
        REG_START_TIMEOUT:  start_timeout  <= cfg_data[16:0];
        REG_END_TIMEOUT:    end_timeout    <= cfg_data[16:0];
        REG_PAUSE_TICKS:    pause_ticks    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SETTLE;
      phase_ticks   <= '0;
      since_trigger <= '0;
      echo_width    <= '0;
      valve_reg     <= 1'b0;
      led_reg       <= LED_OFF;
      distance_reg  <= '0;
      error_reg     <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      phase_ticks   <= phase_ticks_next;
      since_trigger <= since_trigger_next;
      echo_width    <= echo_width_next;
      valve_reg     <= valve_reg_next;
      led_reg       <= led_reg_next;
      distance_reg  <= distance_reg_next;
      error_reg     <= error_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      trigger_level <= trig;
      valve_open    <= valve_reg_next;
      led_color     <= led_reg_next;
      distance_out  <= distance_reg_next;
      result_strobe <= strobe;
      sensor_error  <= error_reg_next;
    end
  end

endmodule

// File: hdl/ulvc_checker.sv
`include "ultrasonic_level_valve_controller_assert.svh"

module ulvc_checker
  import ulvc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        echo_level,
  input logic        out_valid,
  input logic        out_stall,
  input logic        trigger_level,
  input logic        valve_open,
  input logic [1:0]  led_color,
  input logic [17:0] distance_out,
  input logic        result_strobe,
  input logic        sensor_error,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [19:0] cfg_data
);

  logic unused_ok;
  assign unused_ok = in_valid ^ in_stall ^ echo_level ^ cfg_we ^ (|cfg_index) ^ (|cfg_data);

  `ULVC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(distance_out) && $stable(led_color) && $stable(trigger_level))
  `ULVC_ASSERT_NOW(a_error_red, clk, rst, out_valid && sensor_error, !valve_open && led_color == LED_RED)
  `ULVC_ASSERT_NOW(a_valve_green, clk, rst, out_valid, valve_open == (led_color == LED_GREEN))
  `ULVC_ASSERT_NOW(a_trig_no_strobe, clk, rst, out_valid && trigger_level, !result_strobe)

endmodule

bind ultrasonic_level_valve_controller ulvc_checker u_ulvc_checker (.*);

// File: verif/ultrasonic_level_valve_controller_tb.sv
module ultrasonic_level_valve_controller_tb;
  import ulvc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic        trig;
    logic        valve;
    logic [1:0]  led;
    logic [17:0] distance;
    logic        strobe;
    logic        err;
  } tick_result_t;

  class ranger_scoreboard;
    logic [17:0]  thr_dist;
    logic [7:0]   trig_len;
    logic [16:0]  start_to;
    logic [16:0]  end_to;
    logic [19:0]  pause_len;
    phase_t       phase;
    logic [19:0]  ph_ticks;
    logic [16:0]  since_trig;
    logic [16:0]  pulse_width;
    logic         valve;
    logic [1:0]   led;
    logic [17:0]  last_dist;
    logic         err;
    tick_result_t expected_ticks[$];
    int unsigned  n_ticks, n_checked, n_fail, n_green, n_blue, n_timeout, n_writes;

    function new();
      thr_dist    = RST_THRESHOLD_DIST;
      trig_len    = RST_TRIGGER_TICKS;
      start_to    = RST_START_TIMEOUT;
      end_to      = RST_END_TIMEOUT;
      pause_len   = RST_PAUSE_TICKS;
      phase       = PH_SETTLE;
      ph_ticks    = '0;
      since_trig  = '0;
      pulse_width = '0;
      valve       = 1'b0;
      led         = LED_OFF;
      last_dist   = '0;
      err         = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [19:0] data);
      n_writes++;
      case (idx)
        REG_THRESHOLD_DIST: thr_dist = data[17:0];
        REG_TRIGGER_TICKS:  trig_len = data[7:0];
        REG_START_TIMEOUT:  start_to = data[16:0];
        REG_END_TIMEOUT:    end_to = data[16:0];
        REG_PAUSE_TICKS:    pause_len = data;
        default: ;
      endcase
    endfunction

    function void conclude(bit timed_out);
      logic [29:0] prod;
      if (timed_out) begin
        err = 1'b1;
        valve = 1'b0;
        led = LED_RED;
        n_timeout++;
      end else begin
        prod = 30'(pulse_width) * 30'(DIST_MUL);
        last_dist = 18'(prod >> DIST_SHIFT);
        err = 1'b0;
        if (last_dist <= thr_dist) begin
          valve = 1'b1;
          led = LED_GREEN;
          n_green++;
        end else begin
          valve = 1'b0;
          led = LED_BLUE;
          n_blue++;
        end
      end
      ph_ticks = '0;
      phase = (pause_len == 0) ? PH_SETTLE : PH_PAUSE;
    endfunction

    function void take_tick(logic echo);
      tick_result_t r;
      logic [17:0]  elapsed;
      logic [7:0]   tlen;
      r = '0;
      tlen = (trig_len == 0) ? 8'd1 : trig_len;
      case (phase)
        PH_TRIG: begin
          r.trig = 1'b1;
          ph_ticks++;
          if (ph_ticks >= 20'(tlen)) begin
            phase = PH_WAIT;
            ph_ticks = '0;
            since_trig = '0;
            pulse_width = '0;
          end
        end
        PH_WAIT: begin
          elapsed = 18'(since_trig) + 18'd1;
          since_trig = (elapsed > 18'(CNT17_MAX)) ? CNT17_MAX : elapsed[16:0];
          if (echo) begin
            pulse_width = 17'd1;
            phase = PH_MEASURE;
          end else if (elapsed > 18'(start_to)) begin
            r.strobe = 1'b1;
            conclude(1'b1);
          end
        end
        PH_MEASURE: begin
          elapsed = 18'(since_trig) + 18'd1;
          since_trig = (elapsed > 18'(CNT17_MAX)) ? CNT17_MAX : elapsed[16:0];
          if (!echo) begin
            r.strobe = 1'b1;
            conclude(1'b0);
          end else begin
            if (pulse_width < CNT17_MAX) pulse_width++;
            if (elapsed > 18'(end_to)) begin
              r.strobe = 1'b1;
              conclude(1'b1);
            end
          end
        end
        PH_PAUSE: begin
          ph_ticks++;
          if (ph_ticks >= pause_len) begin
            phase = PH_SETTLE;
            ph_ticks = '0;
          end
        end
        default: begin
          if (phase != PH_SETTLE) begin
            phase = PH_SETTLE;
            ph_ticks = '0;
          end
          ph_ticks++;
          if (ph_ticks >= SETTLE_TICKS) begin
            phase = PH_TRIG;
            ph_ticks = '0;
          end
        end
      endcase
      r.valve = valve;
      r.led = led;
      r.distance = last_dist;
      r.err = err;
      expected_ticks.push_back(r);
      n_ticks++;
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction

    function void report_field(string name, logic [17:0] want, logic [17:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        n_fail++;
      end
    endfunction

    function void check_tick_result(tick_result_t got);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %0h", $time, got);
        n_fail++;
        return;
      end
      want = expected_ticks.pop_front();
      n_checked++;
      report_field("trigger_level", 18'(want.trig), 18'(got.trig));
      report_field("valve_open", 18'(want.valve), 18'(got.valve));
      report_field("led_color", 18'(want.led), 18'(got.led));
      report_field("distance_out", want.distance, got.distance);
      report_field("result_strobe", 18'(want.strobe), 18'(got.strobe));
      report_field("sensor_error", 18'(want.err), 18'(got.err));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        echo_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        trigger_level;
  logic        valve_open;
  logic [1:0]  led_color;
  logic [17:0] distance_out;
  logic        result_strobe;
  logic        sensor_error;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  ranger_scoreboard sb = new();

  bit          calm = 1'b0;
  bit          tx_busy = 1'b0;
  int unsigned tx_mode_left = 0;
  bit          jitter = 1'b0;
  int unsigned plan_delay = 0;
  int unsigned plan_width = 0;

  int unsigned stall_left = 0;
  int unsigned rx_mode_left = 0;
  bit          rx_busy = 1'b0;
  bit          long_hold_done = 1'b0;

  ultrasonic_level_valve_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .echo_level   (echo_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .trigger_level(trigger_level),
    .valve_open   (valve_open),
    .led_color    (led_color),
    .distance_out (distance_out),
    .result_strobe(result_strobe),
    .sensor_error (sensor_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall bursts, plus one long hold to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_busy = $urandom_range(0, 1);
        rx_mode_left = $urandom_range(30, 150);
      end else begin
        rx_mode_left--;
      end
      if (!long_hold_done && sb.n_ticks >= 400) begin
        long_hold_done = 1'b1;
        stall_left = 80;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && rx_busy && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.trig = trigger_level;
      got.valve = valve_open;
      got.led = led_color;
      got.distance = distance_out;
      got.strobe = result_strobe;
      got.err = sensor_error;
      sb.check_tick_result(got);
    end
  end

  task automatic send_tick(input logic lvl);
    int unsigned gap;
    if (tx_mode_left == 0) begin
      tx_busy = $urandom_range(0, 1);
      tx_mode_left = $urandom_range(20, 120);
    end else begin
      tx_mode_left--;
    end
    if (!calm && tx_busy && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    echo_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_tick(lvl);
  endtask

  // wait until every tick result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // junk in the bits above each register's width must be dropped
  task automatic apply_settings(input int unsigned thr, input int unsigned trig,
                                input int unsigned st, input int unsigned en,
                                input int unsigned pau);
    logic [2:0] spare;
    spare = 3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
    write_reg(REG_THRESHOLD_DIST, 20'(($urandom & ~32'h3FFFF) | thr));
    write_reg(REG_TRIGGER_TICKS, 20'(($urandom & ~32'hFF) | trig));
    write_reg(spare, 20'($urandom));
    write_reg(REG_START_TIMEOUT, 20'(($urandom & ~32'h1FFFF) | st));
    write_reg(REG_END_TIMEOUT, 20'(($urandom & ~32'h1FFFF) | en));
    write_reg(REG_PAUSE_TICKS, 20'(pau));
    cfg_we <= 1'b0;
  endtask

  // run up to the echo wait, hold echo high for the given ticks, then drop it
  task automatic run_pulse(input int unsigned high_ticks);
    do send_tick(1'b0); while (sb.phase != PH_WAIT);
    repeat (high_ticks) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  function automatic logic next_echo();
    int unsigned room;
    if (sb.phase == PH_WAIT && sb.since_trig == 0) begin
      jitter = ($urandom_range(0, 9) == 0);
      plan_delay = ($urandom_range(0, 6) == 0) ? sb.start_to + 1 : $urandom_range(0, sb.start_to);
      room = (sb.end_to > plan_delay) ? sb.end_to - plan_delay : 1;
      plan_width = ($urandom_range(0, 6) == 0) ? room + 3 : $urandom_range(1, room);
    end
    if (jitter) return 1'($urandom_range(0, 1));
    case (sb.phase)
      PH_WAIT:    return (sb.since_trig >= plan_delay);
      PH_MEASURE: return (sb.pulse_width < plan_width);
      default:    return 1'($urandom_range(0, 1));
    endcase
  endfunction

  initial begin
    int unsigned seg_len;
    int unsigned st;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: short echo, green
    run_pulse(1);
    drain();
    // zero pause, zero trigger length, zero timeouts, threshold floor
    apply_settings(0, 0, 0, 0, 0);
    run_pulse(0);
    run_pulse(2);
    drain();
    // extremes: threshold and end-timeout ceilings, longest pause
    apply_settings(262143, 1, 1, 131071, 1048575);
    run_pulse(1);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      st = $urandom_range(0, 25);
      if (seg == 5) calm = 1'b1;
      apply_settings($urandom_range(0, 90), (seg == 2) ? 255 : $urandom_range(0, 5), st,
                     $urandom_range(0, st + 40), $urandom_range(0, 6));
      seg_len = (seg == 2) ? 280 : 140;
      repeat (seg_len) send_tick(next_echo());
      drain();
    end

    // a long pulse that still measures, then one that runs past the end timeout
    apply_settings($urandom_range(0, 262143), 1, 20, 60, 1);
    run_pulse(55);
    run_pulse(62);
    drain();
    repeat (5) @(posedge clk);

    $display("covered %0d ticks over %0d register writes", sb.n_ticks, sb.n_writes);
    $display("evaluations: %0d green, %0d blue, %0d timeouts; %0d results checked",
             sb.n_green, sb.n_blue, sb.n_timeout, sb.n_checked);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("ultrasonic_level_valve_controller_tb: clean");
    end else begin
      $display("ultrasonic_level_valve_controller_tb: errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout at %0t with %0d results outstanding", $time, sb.pending());
    $display("ultrasonic_level_valve_controller_tb: errors");
    $finish;
  end

endmodule
